>>> rtl/ruc_pkg.sv
package ruc_pkg;

  typedef logic [15:0] unit_t;

  localparam unit_t LatinCaseOfs    = 16'd32;
  localparam unit_t CyrExtraOfs     = 16'd80;
  localparam unit_t ArmenianCaseOfs = 16'd48;

  function automatic unit_t map_latin1(unit_t u);
    unit_t r;
    r = u;
    if (u >= 16'h0061 && u <= 16'h007A) begin
      r = u - LatinCaseOfs;
    end else if (u == 16'h00B5) begin
      r = 16'h039C;
    end else if (u == 16'h00FF) begin
      r = 16'h0178;
    end else if (u >= 16'h00E0 && u <= 16'h00FE && u != 16'h00F7 && u != 16'h00DF) begin
      r = u - LatinCaseOfs;
    end
    return r;
  endfunction

  function automatic unit_t map_latin_ext_a(unit_t u);
    unit_t r;
    logic  odd;
    odd = u[0];
    if (u == 16'h0130 || u == 16'h0131 || u == 16'h0138 || u == 16'h0149 ||
        u == 16'h0178 || u == 16'h017F) begin
      r = u;
    end else if (u <= 16'h0137) begin
      r = odd ? u - 16'd1 : u;
    end else if (u <= 16'h0148) begin
      r = odd ? u : u - 16'd1;
    end else if (u <= 16'h0177) begin
      r = odd ? u - 16'd1 : u;
    end else begin
      r = odd ? u : u - 16'd1;
    end
    return r;
  endfunction

  function automatic unit_t map_greek(unit_t u);
    unit_t r;
    r = u;
    if (u >= 16'h03B1 && u <= 16'h03C1) begin
      r = u - LatinCaseOfs;
    end else if (u == 16'h03C2) begin
      r = 16'h03A3;
    end else if (u >= 16'h03C3 && u <= 16'h03CB) begin
      r = u - LatinCaseOfs;
    end else begin
      case (u)
        16'h03AC: r = 16'h0386;
        16'h03AD: r = 16'h0388;
        16'h03AE: r = 16'h0389;
        16'h03AF: r = 16'h038A;
        16'h03CC: r = 16'h038C;
        16'h03CD: r = 16'h038E;
        16'h03CE: r = 16'h038F;
        16'h0371: r = 16'h0370;
        16'h0373: r = 16'h0372;
        16'h0377: r = 16'h0376;
        16'h037B: r = 16'h03FD;
        16'h037C: r = 16'h03FE;
        16'h037D: r = 16'h03FF;
        16'h03D0: r = 16'h0392;
        16'h03D1: r = 16'h0398;
        16'h03D5: r = 16'h03A6;
        16'h03D6: r = 16'h03A0;
        16'h03D7: r = 16'h03CF;
        16'h03F0: r = 16'h039A;
        16'h03F1: r = 16'h03A1;
        16'h03F2: r = 16'h03F9;
        16'h03F3: r = 16'h037F;
        16'h03F5: r = 16'h0395;
        16'h03F8: r = 16'h03F7;
        16'h03FB: r = 16'h03FA;
        default: begin
          // archaic letters and Coptic pairs: capital even, small odd
          if (u >= 16'h03D8 && u <= 16'h03EF && u[0]) begin
            r = u - 16'd1;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic unit_t map_cyrillic(unit_t u);
    unit_t r;
    logic  odd;
    odd = u[0];
    r = u;
    if (u >= 16'h0430 && u <= 16'h044F) begin
      r = u - LatinCaseOfs;
    end else if (u >= 16'h0450 && u <= 16'h045F) begin
      r = u - CyrExtraOfs;
    end else if (u == 16'h04CF) begin
      r = 16'h04C0;
    end else if (u >= 16'h0460 && u <= 16'h0481 && odd) begin
      r = u - 16'd1;
    end else if (u >= 16'h048A && u <= 16'h04BF && odd) begin
      r = u - 16'd1;
    end else if (u >= 16'h04C1 && u <= 16'h04CE && !odd) begin
      r = u - 16'd1;
    end else if (u >= 16'h04D0 && u <= 16'h052F && odd) begin
      r = u - 16'd1;
    end
    return r;
  endfunction

  function automatic unit_t canon_unit(unit_t u);
    unit_t r;
    if (u < 16'h0100) begin
      r = map_latin1(u);
    end else if (u < 16'h0180) begin
      r = map_latin_ext_a(u);
    end else if (u >= 16'h0370 && u <= 16'h03FF) begin
      r = map_greek(u);
    end else if (u >= 16'h0400 && u <= 16'h052F) begin
      r = map_cyrillic(u);
    end else if (u >= 16'h0561 && u <= 16'h0586) begin
      r = u - ArmenianCaseOfs;
    end else begin
      r = u;
    end
    return r;
  endfunction

endpackage

>>> rtl/regexp_uppercase_canonicalize.sv
// An accepted item is held in the input register, then mapped and loaded into the result
// register, where it stays until the result side takes it.
// Throughput: one item per cycle; a new item is taken each cycle the result side keeps up.
// The mapping is one pass of range compares and a subtract between the two registers.
// Reset (rst, synchronous): both stages empty, ignore_case cleared to 0 (pass-through).
module regexp_uppercase_canonicalize (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ruc_pkg::unit_t       code_unit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ruc_pkg::unit_t       canonical_unit,
  output logic                 was_changed
);
  import ruc_pkg::*;

  logic  ignore_case;
  logic  s1_valid;
  unit_t s1_unit;
  logic  s1_advance;
  unit_t mapped;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_comb begin
    mapped = ignore_case ? canon_unit(s1_unit) : s1_unit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_case <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      ignore_case <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_unit <= code_unit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      canonical_unit <= mapped;
      was_changed    <= (mapped != s1_unit);
    end
  end

endmodule
